// ===== rtl/core/vcc_pkg.sv =====
`timescale 1ns / 1ps
package vcc_pkg;
   localparam int MAX_WIDTH   = 1024;
   localparam int MAX_HEIGHT  = 4096;
   localparam int MAX_KERNEL  = 16;
   localparam int SAMPLE_BITS = 16;
   localparam int COL_BITS    = 10;
   localparam int ROW_BITS    = 12;
   localparam int KIDX_BITS   = 4;
   localparam int KDIM_BITS   = 5;
   localparam int WCFG_BITS   = 11;
   localparam int HCFG_BITS   = 13;
   localparam int PROD_BITS   = 32;
   localparam int SUM_BITS    = 40;
   localparam int FIFO_DEPTH  = 16;
   localparam int FIFO_ABITS  = 4;
   localparam int CSR_IDX_BITS = 2;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_WIDTH   = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] REG_IMAGE_HEIGHT  = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] REG_KERNEL_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_BITS-1:0] REG_KERNEL_HEIGHT = 2'd3;

   typedef struct packed {
      logic                 shift_en;
      logic                 row_on;
      logic [KDIM_BITS-1:0] kw;
   } cell_ctrl_type;

   typedef struct packed {
      logic [ROW_BITS-1:0]        out_row;
      logic [COL_BITS-1:0]        out_col;
      logic signed [SUM_BITS-1:0] dot_sum;
      logic                       frame_last;
   } result_type;
endpackage

// ===== rtl/core/vcc_line_buf.sv =====
`timescale 1ns / 1ps
module vcc_line_buf (
   input  logic                                    clock,
   input  logic                                    wr_en,
   input  logic [vcc_pkg::KIDX_BITS-1:0]           wr_bank,
   input  logic [vcc_pkg::COL_BITS-1:0]            addr,
   input  logic signed [vcc_pkg::SAMPLE_BITS-1:0]  wr_data,
   output logic signed [vcc_pkg::SAMPLE_BITS-1:0]  rd_data [vcc_pkg::MAX_KERNEL]
);
   // One bank per image row modulo the maximum kernel height; all banks read the same column.
   for (genvar b = 0; b < vcc_pkg::MAX_KERNEL; b++) begin : g_bank
      logic signed [vcc_pkg::SAMPLE_BITS-1:0] mem [vcc_pkg::MAX_WIDTH];
      logic signed [vcc_pkg::SAMPLE_BITS-1:0] rd_ff;

      always_ff @(posedge clock) begin
         if (wr_en && wr_bank == vcc_pkg::KIDX_BITS'(b)) begin
            mem[addr] <= wr_data;
         end
         rd_ff <= mem[addr];
      end
      assign rd_data[b] = rd_ff;
   end
endmodule

// ===== rtl/core/vcc_cell.sv =====
`timescale 1ns / 1ps
module vcc_cell (
   input  logic                                    clock,
   input  vcc_pkg::cell_ctrl_type                  ctrl,
   input  logic signed [vcc_pkg::SAMPLE_BITS-1:0]  col_in,
   input  logic signed [vcc_pkg::SAMPLE_BITS-1:0]  coef_in [vcc_pkg::MAX_KERNEL],
   output logic signed [vcc_pkg::SUM_BITS-1:0]     row_sum
);
   localparam int GROUPS = vcc_pkg::MAX_KERNEL / 4;

   logic signed [vcc_pkg::SAMPLE_BITS-1:0] taps_ff [vcc_pkg::MAX_KERNEL];
   logic signed [vcc_pkg::SAMPLE_BITS-1:0] taps_in [vcc_pkg::MAX_KERNEL];
   logic                                   tap_on [vcc_pkg::MAX_KERNEL];
   logic signed [vcc_pkg::PROD_BITS-1:0]   prod_ff [vcc_pkg::MAX_KERNEL];
   logic signed [vcc_pkg::SUM_BITS-1:0]    grp_ff [GROUPS];
   logic signed [vcc_pkg::SUM_BITS-1:0]    grp_in [GROUPS];
   logic signed [vcc_pkg::SUM_BITS-1:0]    row_sum_ff;
   logic signed [vcc_pkg::SUM_BITS-1:0]    row_sum_in;

   // The newest column enters at the last tap in use and older columns move left.
   always_comb begin
      for (int n = 0; n < vcc_pkg::MAX_KERNEL; n++) begin
         if (n == vcc_pkg::MAX_KERNEL - 1 ||
             vcc_pkg::KDIM_BITS'(n + 1) == ctrl.kw) begin
            taps_in[n] = col_in;
         end else begin
            taps_in[n] = taps_ff[(n + 1) % vcc_pkg::MAX_KERNEL];
         end
         tap_on[n] = ctrl.row_on && vcc_pkg::KDIM_BITS'(n) < ctrl.kw;
      end
      for (int g = 0; g < GROUPS; g++) begin
         grp_in[g] = vcc_pkg::SUM_BITS'(prod_ff[4*g]) + vcc_pkg::SUM_BITS'(prod_ff[4*g+1])
                   + vcc_pkg::SUM_BITS'(prod_ff[4*g+2]) + vcc_pkg::SUM_BITS'(prod_ff[4*g+3]);
      end
      row_sum_in = '0;
      for (int g = 0; g < GROUPS; g++) begin
         row_sum_in = row_sum_in + grp_ff[g];
      end
   end

   // Taps outside the kernel may hold samples that were never written, so their
   // products are forced to zero rather than multiplied by a zero coefficient.
   always_ff @(posedge clock) begin
      if (ctrl.shift_en) begin
         taps_ff <= taps_in;
      end
      for (int n = 0; n < vcc_pkg::MAX_KERNEL; n++) begin
         if (tap_on[n]) begin
            prod_ff[n] <= taps_ff[n] * coef_in[n];
         end else begin
            prod_ff[n] <= '0;
         end
      end
      grp_ff     <= grp_in;
      row_sum_ff <= row_sum_in;
   end

   assign row_sum = row_sum_ff;
endmodule

// ===== rtl/core/vcc_out_fifo.sv =====
`timescale 1ns / 1ps
module vcc_out_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  vcc_pkg::result_type    wr_data,
   output logic                   rd_valid,
   input  logic                   rd_ready,
   output vcc_pkg::result_type    rd_data
);
   vcc_pkg::result_type mem_ff [vcc_pkg::FIFO_DEPTH];
   logic [vcc_pkg::FIFO_ABITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [vcc_pkg::FIFO_ABITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [vcc_pkg::FIFO_ABITS:0]   count_ff, count_in;
   logic                           pop;

   assign rd_valid = count_ff != '0;
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + (wr_en ? 1'b1 : 1'b0);
      rd_ptr_in = rd_ptr_ff + (pop ? 1'b1 : 1'b0);
      count_in  = count_ff + (wr_en ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end
endmodule

// ===== rtl/core/valid_2d_cross_correlation.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Handshake             Word
// req       in         req_valid/req_ready   func, coef_row, coef_col, sample
// rsp       out        rsp_valid/rsp_ready   out_row, out_col, dot_sum, frame_last
// csr       in         csr_write_en          index, wdata
// One word is taken per cycle while req_ready is high; each result passes a registered pipeline.
// The depth is set by the line store read, the window shift, the multipliers in each
// row cell and a four-level registered adder tree.
// A coefficient load waits while a result-producing sample is still ahead of the multipliers.
// A 16-entry output queue with credit counting absorbs stalls at the result side.
// Reset clears the raster position, the queue and the credit count, not the stores.
module valid_2d_cross_correlation (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic                                   req_func,
   input  logic [vcc_pkg::KIDX_BITS-1:0]          req_coef_row,
   input  logic [vcc_pkg::KIDX_BITS-1:0]          req_coef_col,
   input  logic signed [vcc_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [vcc_pkg::ROW_BITS-1:0]           rsp_out_row,
   output logic [vcc_pkg::COL_BITS-1:0]           rsp_out_col,
   output logic signed [vcc_pkg::SUM_BITS-1:0]    rsp_dot_sum,
   output logic                                   rsp_frame_last,
   input  logic                                   csr_write_en,
   input  logic [vcc_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [vcc_pkg::HCFG_BITS-1:0]          csr_wdata
);
   localparam int K     = vcc_pkg::MAX_KERNEL;
   localparam int DEPTH = 7;
   localparam int SB    = vcc_pkg::SAMPLE_BITS;

   logic [vcc_pkg::WCFG_BITS-1:0] img_w_ff;
   logic [vcc_pkg::HCFG_BITS-1:0] img_h_ff;
   logic [vcc_pkg::KDIM_BITS-1:0] ker_w_ff, ker_h_ff;
   logic [vcc_pkg::WCFG_BITS-1:0] w_eff;
   logic [vcc_pkg::HCFG_BITS-1:0] h_eff;
   logic [vcc_pkg::KDIM_BITS-1:0] kw_eff, kh_eff;

   logic [vcc_pkg::ROW_BITS-1:0] row_ff, row_in;
   logic [vcc_pkg::COL_BITS-1:0] col_ff, col_in;
   logic [vcc_pkg::FIFO_ABITS:0] credit_ff, credit_in;

   logic signed [SB-1:0] kernel_ff [K][K];

   logic take, take_sample, take_load, produce, is_last;
   logic [vcc_pkg::ROW_BITS-1:0] top;
   logic [vcc_pkg::COL_BITS-1:0] left;

   logic                         pv_ff [1:DEPTH];
   vcc_pkg::result_type          meta_ff [1:DEPTH];
   vcc_pkg::result_type          meta_new;
   logic                         s1_shift_ff;
   logic signed [SB-1:0]         s1_sample_ff;
   logic [vcc_pkg::KIDX_BITS-1:0] s1_bank_ff;

   logic signed [SB-1:0] rd_data [K];
   logic signed [SB-1:0] column [K];
   logic signed [vcc_pkg::SUM_BITS-1:0] row_sum [K];
   logic signed [vcc_pkg::SUM_BITS-1:0] quad_ff [K/4];
   logic signed [vcc_pkg::SUM_BITS-1:0] quad_in [K/4];
   logic signed [vcc_pkg::SUM_BITS-1:0] total_ff, total_in;
   vcc_pkg::result_type fifo_wr, fifo_rd;

   always_comb begin
      w_eff  = (img_w_ff == '0) ? vcc_pkg::WCFG_BITS'(1) :
               (img_w_ff > vcc_pkg::WCFG_BITS'(vcc_pkg::MAX_WIDTH)) ?
               vcc_pkg::WCFG_BITS'(vcc_pkg::MAX_WIDTH) : img_w_ff;
      h_eff  = (img_h_ff == '0) ? vcc_pkg::HCFG_BITS'(1) :
               (img_h_ff > vcc_pkg::HCFG_BITS'(vcc_pkg::MAX_HEIGHT)) ?
               vcc_pkg::HCFG_BITS'(vcc_pkg::MAX_HEIGHT) : img_h_ff;
      kw_eff = (ker_w_ff == '0) ? vcc_pkg::KDIM_BITS'(1) :
               (ker_w_ff > vcc_pkg::KDIM_BITS'(K)) ? vcc_pkg::KDIM_BITS'(K) : ker_w_ff;
      kh_eff = (ker_h_ff == '0) ? vcc_pkg::KDIM_BITS'(1) :
               (ker_h_ff > vcc_pkg::KDIM_BITS'(K)) ? vcc_pkg::KDIM_BITS'(K) : ker_h_ff;
   end

   // A load must not change coefficients that a sample ahead of the multipliers still needs.
   always_comb begin
      if (req_func == vcc_pkg::FUNC_SAMPLE) begin
         req_ready = credit_ff < (vcc_pkg::FIFO_ABITS+1)'(vcc_pkg::FIFO_DEPTH);
      end else begin
         req_ready = !pv_ff[1] && !pv_ff[2];
      end
   end

   always_comb begin
      take        = req_valid && req_ready;
      take_sample = take && req_func == vcc_pkg::FUNC_SAMPLE;
      take_load   = take && req_func == vcc_pkg::FUNC_LOAD;
      produce = ({8'd0, kh_eff} <= h_eff) && ({6'd0, kw_eff} <= w_eff) &&
                ({1'b0, row_ff} + 13'd1 >= {8'd0, kh_eff}) &&
                ({1'b0, col_ff} + 11'd1 >= {6'd0, kw_eff});
      top  = vcc_pkg::ROW_BITS'({1'b0, row_ff} + 13'd1 - {8'd0, kh_eff});
      left = vcc_pkg::COL_BITS'({1'b0, col_ff} + 11'd1 - {6'd0, kw_eff});
      is_last = ({1'b0, row_ff} == h_eff - 13'd1) && ({1'b0, col_ff} == w_eff - 11'd1);
      meta_new.out_row    = top;
      meta_new.out_col    = left;
      meta_new.dot_sum    = '0;
      meta_new.frame_last = is_last;

      if ({1'b0, col_ff} + 11'd1 >= w_eff) begin
         col_in = '0;
         row_in = ({1'b0, row_ff} + 13'd1 >= h_eff) ? '0 : row_ff + 1'b1;
      end else begin
         col_in = col_ff + 1'b1;
         row_in = row_ff;
      end

      credit_in = credit_ff + ((take_sample && produce) ? 1'b1 : 1'b0)
                - ((rsp_valid && rsp_ready) ? 1'b1 : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         img_w_ff  <= vcc_pkg::WCFG_BITS'(vcc_pkg::MAX_WIDTH);
         img_h_ff  <= vcc_pkg::HCFG_BITS'(vcc_pkg::MAX_HEIGHT);
         ker_w_ff  <= vcc_pkg::KDIM_BITS'(K);
         ker_h_ff  <= vcc_pkg::KDIM_BITS'(K);
         row_ff    <= '0;
         col_ff    <= '0;
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
         if (csr_write_en) begin
            case (csr_index)
               vcc_pkg::REG_IMAGE_WIDTH:   img_w_ff <= csr_wdata[vcc_pkg::WCFG_BITS-1:0];
               vcc_pkg::REG_IMAGE_HEIGHT:  img_h_ff <= csr_wdata;
               vcc_pkg::REG_KERNEL_WIDTH:  ker_w_ff <= csr_wdata[vcc_pkg::KDIM_BITS-1:0];
               vcc_pkg::REG_KERNEL_HEIGHT: ker_h_ff <= csr_wdata[vcc_pkg::KDIM_BITS-1:0];
               default: ;
            endcase
            row_ff <= '0;
            col_ff <= '0;
         end else if (take_sample) begin
            row_ff <= row_in;
            col_ff <= col_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take_load) begin
         kernel_ff[req_coef_row][req_coef_col] <= req_sample;
      end
   end

   // Result-valid pipeline; payload follows without reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i <= DEPTH; i++) begin
            pv_ff[i] <= 1'b0;
         end
         s1_shift_ff <= 1'b0;
      end else begin
         pv_ff[1]    <= take_sample && produce;
         s1_shift_ff <= take_sample;
         for (int i = 2; i <= DEPTH; i++) begin
            pv_ff[i] <= pv_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      meta_ff[1]   <= meta_new;
      s1_sample_ff <= req_sample;
      s1_bank_ff   <= row_ff[vcc_pkg::KIDX_BITS-1:0];
      for (int i = 2; i <= DEPTH; i++) begin
         meta_ff[i] <= meta_ff[i-1];
      end
   end

   vcc_line_buf u_line_buf (
      .clock   (clock),
      .wr_en   (take_sample),
      .wr_bank (row_ff[vcc_pkg::KIDX_BITS-1:0]),
      .addr    (col_ff),
      .wr_data (req_sample),
      .rd_data (rd_data)
   );

   // Kernel row m sees image row (current - kh + 1 + m); the bottom row is the sample itself.
   always_comb begin
      for (int m = 0; m < K; m++) begin
         if (vcc_pkg::KDIM_BITS'(m + 1) == kh_eff) begin
            column[m] = s1_sample_ff;
         end else begin
            column[m] = rd_data[vcc_pkg::KIDX_BITS'(s1_bank_ff + vcc_pkg::KIDX_BITS'(m + 1)
                                                   - kh_eff[vcc_pkg::KIDX_BITS-1:0])];
         end
      end
   end

   for (genvar m = 0; m < K; m++) begin : g_row
      vcc_pkg::cell_ctrl_type ctrl;
      assign ctrl.shift_en = s1_shift_ff;
      assign ctrl.row_on   = vcc_pkg::KDIM_BITS'(m) < kh_eff;
      assign ctrl.kw       = kw_eff;

      vcc_cell u_cell (
         .clock   (clock),
         .ctrl    (ctrl),
         .col_in  (column[m]),
         .coef_in (kernel_ff[m]),
         .row_sum (row_sum[m])
      );
   end

   always_comb begin
      for (int q = 0; q < K/4; q++) begin
         quad_in[q] = row_sum[4*q] + row_sum[4*q+1] + row_sum[4*q+2] + row_sum[4*q+3];
      end
      total_in = '0;
      for (int q = 0; q < K/4; q++) begin
         total_in = total_in + quad_ff[q];
      end
   end

   always_ff @(posedge clock) begin
      quad_ff  <= quad_in;
      total_ff <= total_in;
   end

   always_comb begin
      fifo_wr         = meta_ff[DEPTH];
      fifo_wr.dot_sum = total_ff;
   end

   vcc_out_fifo u_out_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pv_ff[DEPTH]),
      .wr_data  (fifo_wr),
      .rd_valid (rsp_valid),
      .rd_ready (rsp_ready),
      .rd_data  (fifo_rd)
   );

   assign rsp_out_row    = fifo_rd.out_row;
   assign rsp_out_col    = fifo_rd.out_col;
   assign rsp_dot_sum    = fifo_rd.dot_sum;
   assign rsp_frame_last = fifo_rd.frame_last;
endmodule

// ===== rtl/core/vcc_checker.sv =====
`timescale 1ns / 1ps
module vcc_props (
   input logic                                   clock,
   input logic                                   reset,
   input logic                                   req_valid,
   input logic                                   req_ready,
   input logic                                   req_func,
   input logic                                   rsp_valid,
   input logic                                   rsp_ready,
   input logic signed [vcc_pkg::SUM_BITS-1:0]    rsp_dot_sum,
   input logic [vcc_pkg::ROW_BITS-1:0]           rsp_out_row
);
   // A held result word keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dot_sum) && $stable(rsp_out_row))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

   // An empty queue refills only from a sample taken as far back as the pipeline is deep.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      !$past(reset, 8) && $rose(rsp_valid) |->
         $past(req_valid && req_ready && req_func == vcc_pkg::FUNC_SAMPLE, 8))
      else $error("result without a matching sample");
endmodule

bind valid_2d_cross_correlation vcc_props u_vcc_props (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .req_func    (req_func),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_dot_sum (rsp_dot_sum),
   .rsp_out_row (rsp_out_row)
);

// ===== tb/vcc_checker.sv =====
`timescale 1ns / 1ps
module vcc_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic                                   req_func,
   input  logic [vcc_pkg::KIDX_BITS-1:0]          req_coef_row,
   input  logic [vcc_pkg::KIDX_BITS-1:0]          req_coef_col,
   input  logic signed [vcc_pkg::SAMPLE_BITS-1:0] req_sample,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic [vcc_pkg::ROW_BITS-1:0]           rsp_out_row,
   input  logic [vcc_pkg::COL_BITS-1:0]           rsp_out_col,
   input  logic signed [vcc_pkg::SUM_BITS-1:0]    rsp_dot_sum,
   input  logic                                   rsp_frame_last,
   input  logic                                   csr_write_en,
   input  logic [vcc_pkg::CSR_IDX_BITS-1:0]       csr_index,
   input  logic [vcc_pkg::HCFG_BITS-1:0]          csr_wdata,
   output int                                     fail_count,
   output int                                     pending,
   output int                                     window_count
);
   logic signed [vcc_pkg::SAMPLE_BITS-1:0] coef_mem [vcc_pkg::MAX_KERNEL][vcc_pkg::MAX_KERNEL];
   logic signed [vcc_pkg::SAMPLE_BITS-1:0] line_mem [vcc_pkg::MAX_KERNEL][vcc_pkg::MAX_WIDTH];
   int unsigned cfg_width, cfg_height, cfg_kwidth, cfg_kheight;
   int unsigned row_pos, col_pos;
   vcc_pkg::result_type window_q [$];
   vcc_pkg::result_type got, want;

   function automatic int unsigned clamp_dim(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   // Updates the line store and raster position for one image word and queues the
   // window sum it completes, if any.
   task automatic predict_window(logic signed [vcc_pkg::SAMPLE_BITS-1:0] pix);
      int unsigned w, h, kw, kh, r, c, top, left;
      longint acc;
      vcc_pkg::result_type res;
      w  = clamp_dim(cfg_width, vcc_pkg::MAX_WIDTH);
      h  = clamp_dim(cfg_height, vcc_pkg::MAX_HEIGHT);
      kw = clamp_dim(cfg_kwidth, vcc_pkg::MAX_KERNEL);
      kh = clamp_dim(cfg_kheight, vcc_pkg::MAX_KERNEL);
      r = row_pos;
      c = col_pos;
      if (r >= h) r = h - 1;
      if (c >= w) c = w - 1;
      line_mem[r % vcc_pkg::MAX_KERNEL][c] = pix;
      if (kh <= h && kw <= w && r + 1 >= kh && c + 1 >= kw) begin
         top  = r + 1 - kh;
         left = c + 1 - kw;
         acc  = 0;
         for (int m = 0; m < kh; m++)
            for (int n = 0; n < kw; n++)
               acc += longint'(line_mem[(top + m) % vcc_pkg::MAX_KERNEL][left + n])
                      * longint'(coef_mem[m][n]);
         res.out_row    = top[vcc_pkg::ROW_BITS-1:0];
         res.out_col    = left[vcc_pkg::COL_BITS-1:0];
         res.dot_sum    = acc[vcc_pkg::SUM_BITS-1:0];
         res.frame_last = (r == h - 1 && c == w - 1);
         window_q.push_back(res);
      end
      if (c + 1 >= w) begin
         col_pos = 0;
         row_pos = (r + 1 >= h) ? 0 : r + 1;
      end else begin
         col_pos = c + 1;
         row_pos = r;
      end
   endtask

   initial begin
      fail_count   = 0;
      window_count = 0;
      pending      = 0;
   end

   always @(posedge clock) begin
      if (reset) begin
         cfg_width   = vcc_pkg::MAX_WIDTH;
         cfg_height  = vcc_pkg::MAX_HEIGHT;
         cfg_kwidth  = vcc_pkg::MAX_KERNEL;
         cfg_kheight = vcc_pkg::MAX_KERNEL;
         row_pos     = 0;
         col_pos     = 0;
         window_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.out_row    = rsp_out_row;
            got.out_col    = rsp_out_col;
            got.dot_sum    = rsp_dot_sum;
            got.frame_last = rsp_frame_last;
            window_count++;
            if (window_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("unexpected result word: row %0d col %0d sum %0d last %0d",
                           got.out_row, got.out_col, got.dot_sum, got.frame_last);
            end else begin
               want = window_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("result mismatch: expected row %0d col %0d sum %0d last %0d, %s",
                              want.out_row, want.out_col, want.dot_sum, want.frame_last,
                              $sformatf("got row %0d col %0d sum %0d last %0d",
                                        got.out_row, got.out_col, got.dot_sum,
                                        got.frame_last));
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index)
               vcc_pkg::REG_IMAGE_WIDTH:
                  cfg_width   = int'(csr_wdata[vcc_pkg::WCFG_BITS-1:0]);
               vcc_pkg::REG_IMAGE_HEIGHT:
                  cfg_height  = int'(csr_wdata[vcc_pkg::HCFG_BITS-1:0]);
               vcc_pkg::REG_KERNEL_WIDTH:
                  cfg_kwidth  = int'(csr_wdata[vcc_pkg::KDIM_BITS-1:0]);
               vcc_pkg::REG_KERNEL_HEIGHT:
                  cfg_kheight = int'(csr_wdata[vcc_pkg::KDIM_BITS-1:0]);
               default: ;
            endcase
            row_pos = 0;
            col_pos = 0;
         end
         if (req_valid && req_ready) begin
            if (req_func == vcc_pkg::FUNC_LOAD)
               coef_mem[req_coef_row][req_coef_col] = req_sample;
            else
               predict_window(req_sample);
         end
      end
      pending = window_q.size();
   end
endmodule

// ===== tb/tb_valid_2d_cross_correlation.sv =====
`timescale 1ns / 1ps
module tb_valid_2d_cross_correlation;
   logic clock, reset;
   logic req_valid, req_ready, req_func;
   logic [vcc_pkg::KIDX_BITS-1:0] req_coef_row, req_coef_col;
   logic signed [vcc_pkg::SAMPLE_BITS-1:0] req_sample;
   logic rsp_valid, rsp_ready;
   logic [vcc_pkg::ROW_BITS-1:0] rsp_out_row;
   logic [vcc_pkg::COL_BITS-1:0] rsp_out_col;
   logic signed [vcc_pkg::SUM_BITS-1:0] rsp_dot_sum;
   logic rsp_frame_last;
   logic csr_write_en;
   logic [vcc_pkg::CSR_IDX_BITS-1:0] csr_index;
   logic [vcc_pkg::HCFG_BITS-1:0] csr_wdata;
   int fail_count, pending, window_count;
   int burst_left, load_words, image_words, phase_count, random_words;
   bit hold_go, hold_done;

   valid_2d_cross_correlation dut (.*);

   vcc_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("tb_valid_2d_cross_correlation NOT OK");
      $finish;
   end

   // The receiver cycles through always ready, coin-flip and sparse patterns, and
   // once holds off for a long stretch so that the output queue fills.
   initial begin
      int unsigned cyc;
      cyc = 0;
      rsp_ready = 0;
      forever begin
         @(negedge clock);
         cyc++;
         if (hold_go && !hold_done) begin
            rsp_ready <= 0;
            repeat (400) @(negedge clock);
            hold_done = 1;
         end else begin
            case ((cyc / 97) % 3)
               0: rsp_ready <= 1;
               1: rsp_ready <= 1'($urandom_range(0, 1));
               default: rsp_ready <= (cyc % 5 == 0);
            endcase
         end
      end
   end

   function automatic logic signed [vcc_pkg::SAMPLE_BITS-1:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7fff;
         2: return 16'sh0000;
         3: return 16'shffff;
         default: return vcc_pkg::SAMPLE_BITS'($urandom);
      endcase
   endfunction

   // Offers one word in bursts with random gaps between them; returns at the falling
   // edge after it is taken, with valid still high.
   task automatic send_word(logic f, int unsigned kr, int unsigned kc,
                            logic signed [vcc_pkg::SAMPLE_BITS-1:0] v);
      int unsigned gap;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap != 0) begin
            req_valid <= 0;
            repeat (gap) @(negedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_valid    <= 1;
      req_func     <= f;
      req_coef_row <= kr[vcc_pkg::KIDX_BITS-1:0];
      req_coef_col <= kc[vcc_pkg::KIDX_BITS-1:0];
      req_sample   <= v;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      burst_left--;
      if (f == vcc_pkg::FUNC_LOAD) load_words++;
      else image_words++;
   endtask

   task automatic drain();
      req_valid <= 0;
      while (pending != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   task automatic set_config(int unsigned w, int unsigned h, int unsigned kw, int unsigned kh);
      drain();
      csr_write_en <= 1;
      csr_index <= vcc_pkg::REG_IMAGE_WIDTH;
      csr_wdata <= vcc_pkg::HCFG_BITS'(w);
      @(negedge clock);
      csr_index <= vcc_pkg::REG_IMAGE_HEIGHT;
      csr_wdata <= vcc_pkg::HCFG_BITS'(h);
      @(negedge clock);
      csr_index <= vcc_pkg::REG_KERNEL_WIDTH;
      csr_wdata <= vcc_pkg::HCFG_BITS'(kw);
      @(negedge clock);
      csr_index <= vcc_pkg::REG_KERNEL_HEIGHT;
      csr_wdata <= vcc_pkg::HCFG_BITS'(kh);
      @(negedge clock);
      csr_write_en <= 0;
      phase_count++;
   endtask

   task automatic send_image(int unsigned count, logic signed [vcc_pkg::SAMPLE_BITS-1:0] fixed,
                             bit use_fixed, int unsigned load_pct);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < load_pct)
            send_word(vcc_pkg::FUNC_LOAD, $urandom_range(0, 15), $urandom_range(0, 15),
                      pick_value());
         send_word(vcc_pkg::FUNC_SAMPLE, $urandom, $urandom,
                   use_fixed ? fixed : pick_value());
      end
   endtask

   initial begin
      int unsigned w, h, kw, kh, n;
      reset = 1;
      req_valid = 0;
      req_func = vcc_pkg::FUNC_LOAD;
      req_coef_row = 0;
      req_coef_col = 0;
      req_sample = 0;
      csr_write_en = 0;
      csr_index = vcc_pkg::REG_IMAGE_WIDTH;
      csr_wdata = 0;
      burst_left = 0;
      load_words = 0;
      image_words = 0;
      phase_count = 0;
      random_words = 0;
      hold_go = 0;
      hold_done = 0;
      repeat (2) @(negedge clock);
      reset = 0;

      // Full 16 by 16 kernel and image at the most negative value: the largest sum.
      set_config(16, 16, 16, 16);
      for (int r = 0; r < 16; r++)
         for (int c = 0; c < 16; c++)
            send_word(vcc_pkg::FUNC_LOAD, r, c, 16'sh8000);
      send_image(256, 16'sh8000, 1, 0);

      // Oversized width and zero kernel width; the long receiver hold-off falls here.
      set_config(2047, 1, 0, 1);
      hold_go = 1;
      send_image(60, 0, 0, 0);
      // Tallest image, one column, oversized kernel height; a partial frame only.
      set_config(1, 8191, 1, 31);
      send_image(40, 0, 0, 0);
      // Zero-sized image: every sample is a one-by-one frame.
      set_config(0, 0, 1, 1);
      send_image(3, 0, 0, 0);
      // Kernel wider than the image gives nothing.
      set_config(4, 4, 8, 2);
      send_image(16, 0, 0, 0);
      // Coefficient reloads in the middle of a frame.
      set_config(5, 5, 3, 3);
      send_image(25, 0, 0, 30);

      while (random_words < 180) begin
         w  = $urandom_range(1, 20);
         h  = $urandom_range(1, 12);
         kw = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
         kh = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6);
         set_config(w, h, kw, kh);
         n = w * h * $urandom_range(1, 2);
         if ($urandom_range(0, 4) == 0) n = $urandom_range(1, n);
         if (n > 180 - random_words) n = 180 - random_words;
         send_image(n, 0, 0, 8);
         random_words += n;
      end
      drain();

      $display("%0d phases, %0d coefficient loads and %0d image samples sent;",
               phase_count, load_words, image_words);
      $display("%0d window sums checked, long output hold-off %s.",
               window_count, hold_done ? "done" : "missed");
      if (fail_count == 0 && pending == 0)
         $display("tb_valid_2d_cross_correlation OK");
      else
         $display("tb_valid_2d_cross_correlation NOT OK");
      $finish;
   end
endmodule
